FILE: rtl/bmra_pkg.sv
// bmra_pkg: shared types and constants of the banked memory request arbiter
// item structs, kind codes, controller states and controller/datapath links
// no dependencies
package bmra_pkg;

   localparam logic [1:0] KIND_REQUEST  = 2'd0;
   localparam logic [1:0] KIND_TICK     = 2'd1;
   localparam logic [1:0] KIND_RESPONSE = 2'd2;

   localparam logic [4:0] LIMIT_RESET = 5'd16;

   typedef struct packed {
      logic [1:0]  kind;
      logic [2:0]  bank;
      logic [1:0]  upstream;
      logic        is_write;
      logic [31:0] req_addr;
      logic [15:0] req_tag;
      logic [7:0]  downstream_ready;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic        accepted;
      logic [2:0]  out_bank;
      logic [1:0]  out_upstream;
      logic        out_is_write;
      logic [31:0] out_addr;
      logic [15:0] out_tag;
      logic        last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_REQ,
      ST_TICK_INIT,
      ST_TICK_PICK,
      ST_TICK_EMIT,
      ST_RESP_START,
      ST_RESP_READ,
      ST_RESP_CMP,
      ST_RESP_SHR,
      ST_RESP_SHW,
      ST_RESP_HIT,
      ST_RESP_MISS
   } state_type;

   typedef struct packed {
      logic load;
      logic do_req;
      logic tick_init;
      logic grant;
      logic emit_grant;
      logic emit_null;
      logic idx_clear;
      logic idx_inc;
      logic tab_rd_idx;
      logic tab_rd_next;
      logic tab_wr_shift;
      logic latch_hit;
      logic emit_hit;
      logic emit_miss;
   } cmd_type;

   typedef struct packed {
      logic [1:0] in_kind;
      logic       out_free;
      logic       mask_zero;
      logic       grant_last;
      logic       bank_ok;
      logic       cnt_zero;
      logic       addr_match;
      logic       next_lt_cnt;
      logic       next2_lt_cnt;
   } status_type;

endpackage

FILE: rtl/bmra_ctrl.sv
// bmra_ctrl: sequencing state machine of the arbiter
// issues datapath commands from datapath status; uses bmra_pkg
module bmra_ctrl
   import bmra_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               case (status.in_kind)
                  KIND_REQUEST:  state_in = ST_REQ;
                  KIND_TICK:     state_in = ST_TICK_INIT;
                  KIND_RESPONSE: state_in = ST_RESP_START;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end
         ST_REQ: begin
            if (status.out_free) begin
               cmd.do_req = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         ST_TICK_INIT: begin
            cmd.tick_init = 1'b1;
            state_in      = ST_TICK_PICK;
         end
         ST_TICK_PICK: begin
            if (status.mask_zero) begin
               if (status.out_free) begin
                  cmd.emit_null = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.grant = 1'b1;
               state_in  = ST_TICK_EMIT;
            end
         end
         ST_TICK_EMIT: begin
            if (status.out_free) begin
               cmd.emit_grant = 1'b1;
               state_in = status.grant_last ? ST_IDLE : ST_TICK_PICK;
            end
         end
         ST_RESP_START: begin
            cmd.idx_clear = 1'b1;
            if (!status.bank_ok || status.cnt_zero) begin
               state_in = ST_RESP_MISS;
            end else begin
               state_in = ST_RESP_READ;
            end
         end
         ST_RESP_READ: begin
            cmd.tab_rd_idx = 1'b1;
            state_in       = ST_RESP_CMP;
         end
         ST_RESP_CMP: begin
            if (status.addr_match) begin
               cmd.latch_hit = 1'b1;
               state_in = status.next_lt_cnt ? ST_RESP_SHR : ST_RESP_HIT;
            end else begin
               cmd.idx_inc = 1'b1;
               state_in = status.next_lt_cnt ? ST_RESP_READ : ST_RESP_MISS;
            end
         end
         ST_RESP_SHR: begin
            cmd.tab_rd_next = 1'b1;
            state_in        = ST_RESP_SHW;
         end
         ST_RESP_SHW: begin
            cmd.tab_wr_shift = 1'b1;
            cmd.idx_inc      = 1'b1;
            state_in = status.next2_lt_cnt ? ST_RESP_SHR : ST_RESP_HIT;
         end
         ST_RESP_HIT: begin
            if (status.out_free) begin
               cmd.emit_hit = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         ST_RESP_MISS: begin
            if (status.out_free) begin
               cmd.emit_miss = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

FILE: rtl/bmra_dp.sv
// bmra_dp: datapath of the arbiter
// fifo memories, pointers and counts, outstanding table, limit and result register
// uses bmra_pkg, driven by bmra_ctrl commands
module bmra_dp
   import bmra_pkg::*;
#(
   parameter int BANK_COUNT     = 8,
   parameter int UPSTREAM_COUNT = 4,
   parameter int BUF_DEPTH      = 16
) (
   input  logic       clock,
   input  logic       reset,
   input  cmd_type    cmd,
   output status_type status,
   input  req_type    req_item,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_item,
   input  logic       csr_write,
   input  logic [4:0] csr_data
);

   localparam int BW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
   localparam int UW = (UPSTREAM_COUNT > 1) ? $clog2(UPSTREAM_COUNT) : 1;
   localparam int PW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
   localparam int CW = $clog2(BUF_DEPTH + 1);
   localparam int LW = (CW > 5) ? CW : 5;
   localparam int FA = BW + UW + PW;
   localparam int TA = BW + PW;
   localparam int TW = 48 + UW;

   // control registers
   logic [4:0]            limit_ff, limit_in;
   req_type               item_ff, item_in;
   logic [CW-1:0]         rd_cnt_ff [BANK_COUNT][UPSTREAM_COUNT];
   logic [CW-1:0]         rd_cnt_in [BANK_COUNT][UPSTREAM_COUNT];
   logic [CW-1:0]         wr_cnt_ff [BANK_COUNT][UPSTREAM_COUNT];
   logic [CW-1:0]         wr_cnt_in [BANK_COUNT][UPSTREAM_COUNT];
   logic [PW-1:0]         rd_head_ff [BANK_COUNT][UPSTREAM_COUNT];
   logic [PW-1:0]         rd_head_in [BANK_COUNT][UPSTREAM_COUNT];
   logic [PW-1:0]         wr_head_ff [BANK_COUNT][UPSTREAM_COUNT];
   logic [PW-1:0]         wr_head_in [BANK_COUNT][UPSTREAM_COUNT];
   logic [UW-1:0]         rd_ptr_ff [BANK_COUNT];
   logic [UW-1:0]         rd_ptr_in [BANK_COUNT];
   logic [UW-1:0]         wr_ptr_ff [BANK_COUNT];
   logic [UW-1:0]         wr_ptr_in [BANK_COUNT];
   logic [CW-1:0]         oc_ff [BANK_COUNT];
   logic [CW-1:0]         oc_in [BANK_COUNT];
   logic [BANK_COUNT-1:0] mask_ff, mask_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // payload registers
   logic [BW-1:0]         g_bank_ff, g_bank_in;
   logic [UW-1:0]         g_up_ff, g_up_in;
   logic                  g_write_ff, g_write_in;
   logic                  g_last_ff, g_last_in;
   logic [TW-1:0]         hit_ff, hit_in;
   rsp_type               rsp_ff, rsp_in;
   logic [47:0]           rd_q_ff, wr_q_ff;
   logic [TW-1:0]         tab_q_ff;

   // memories
   logic [47:0]           rd_mem [1 << FA];
   logic [47:0]           wr_mem [1 << FA];
   logic [TW-1:0]         tab_mem [1 << TA];

   logic [BW-1:0]         ib;
   logic [UW-1:0]         iu;
   logic                  bank_ok, up_ok, wr_ok, rd_ok, admit;
   logic [LW-1:0]         lim;
   logic [PW-1:0]         push_head;
   logic [CW-1:0]         push_cnt;
   logic [CW:0]           push_sum;
   logic [PW-1:0]         push_pos;
   logic [BANK_COUNT-1:0] nonempty;
   logic [BW-1:0]         gb;
   logic [BANK_COUNT-1:0] rest_mask;
   logic                  found_r, found_w;
   logic [UW-1:0]         ur, uw, gu;
   logic [UW:0]           rsum, wsum;
   logic [PW-1:0]         pop_head, pop_head_nx;
   logic [UW-1:0]         ptr_nx;
   logic [CW:0]           idx_p1, idx_p2;
   logic                  tab_we;
   logic [TA-1:0]         tab_waddr, tab_raddr;
   logic [TW-1:0]         tab_wdata;
   logic                  out_free;

   assign ib      = item_ff.bank[BW-1:0];
   assign iu      = UW'(item_ff.upstream);
   assign bank_ok = {1'b0, item_ff.bank} < 4'(BANK_COUNT);
   assign up_ok   = {3'b0, item_ff.upstream} < 5'(UPSTREAM_COUNT);
   assign lim     = (LW'(limit_ff) > LW'(BUF_DEPTH)) ? LW'(BUF_DEPTH) : LW'(limit_ff);
   assign wr_ok   = LW'(wr_cnt_ff[ib][iu]) < lim;
   assign rd_ok   = (LW'(oc_ff[ib]) < lim) && (rd_cnt_ff[ib][iu] < CW'(BUF_DEPTH));
   assign admit   = bank_ok && up_ok && (item_ff.is_write ? wr_ok : rd_ok);

   // ring position of the next free slot
   assign push_head = item_ff.is_write ? wr_head_ff[ib][iu] : rd_head_ff[ib][iu];
   assign push_cnt  = item_ff.is_write ? wr_cnt_ff[ib][iu] : rd_cnt_ff[ib][iu];
   assign push_sum  = (CW+1)'(push_head) + (CW+1)'(push_cnt);
   assign push_pos  = (push_sum >= (CW+1)'(BUF_DEPTH)) ?
                      PW'(push_sum - (CW+1)'(BUF_DEPTH)) : PW'(push_sum);

   always_comb begin
      for (int b = 0; b < BANK_COUNT; b++) begin
         nonempty[b] = 1'b0;
         for (int u = 0; u < UPSTREAM_COUNT; u++) begin
            if (rd_cnt_ff[b][u] != '0 || wr_cnt_ff[b][u] != '0) begin
               nonempty[b] = 1'b1;
            end
         end
      end
   end

   // lowest pending bank
   always_comb begin
      gb = '0;
      for (int b = BANK_COUNT - 1; b >= 0; b--) begin
         if (mask_ff[b]) begin
            gb = BW'(b);
         end
      end
      for (int b = 0; b < BANK_COUNT; b++) begin
         rest_mask[b] = mask_ff[b] && (BW'(b) != gb);
      end
   end

   // round-robin search from each pointer
   always_comb begin
      found_r = 1'b0;
      found_w = 1'b0;
      ur      = '0;
      uw      = '0;
      rsum    = '0;
      wsum    = '0;
      for (int k = 0; k < UPSTREAM_COUNT; k++) begin
         rsum = (UW+1)'(rd_ptr_ff[gb]) + (UW+1)'(k);
         if (rsum >= (UW+1)'(UPSTREAM_COUNT)) begin
            rsum = rsum - (UW+1)'(UPSTREAM_COUNT);
         end
         if (!found_r && rd_cnt_ff[gb][rsum[UW-1:0]] != '0) begin
            found_r = 1'b1;
            ur      = rsum[UW-1:0];
         end
         wsum = (UW+1)'(wr_ptr_ff[gb]) + (UW+1)'(k);
         if (wsum >= (UW+1)'(UPSTREAM_COUNT)) begin
            wsum = wsum - (UW+1)'(UPSTREAM_COUNT);
         end
         if (!found_w && wr_cnt_ff[gb][wsum[UW-1:0]] != '0) begin
            found_w = 1'b1;
            uw      = wsum[UW-1:0];
         end
      end
   end

   assign gu          = found_r ? ur : uw;
   assign pop_head    = found_r ? rd_head_ff[gb][gu] : wr_head_ff[gb][gu];
   assign pop_head_nx = (pop_head == PW'(BUF_DEPTH - 1)) ? '0 : pop_head + 1'b1;
   assign ptr_nx      = (gu == UW'(UPSTREAM_COUNT - 1)) ? '0 : gu + 1'b1;

   assign idx_p1 = (CW+1)'(idx_ff) + 1'b1;
   assign idx_p2 = (CW+1)'(idx_ff) + 2'd2;

   // state updates
   always_comb begin
      limit_in   = csr_write ? csr_data : limit_ff;
      item_in    = cmd.load ? req_item : item_ff;
      rd_cnt_in  = rd_cnt_ff;
      wr_cnt_in  = wr_cnt_ff;
      rd_head_in = rd_head_ff;
      wr_head_in = wr_head_ff;
      rd_ptr_in  = rd_ptr_ff;
      wr_ptr_in  = wr_ptr_ff;
      oc_in      = oc_ff;
      mask_in    = mask_ff;
      idx_in     = idx_ff;
      g_bank_in  = g_bank_ff;
      g_up_in    = g_up_ff;
      g_write_in = g_write_ff;
      g_last_in  = g_last_ff;
      hit_in     = cmd.latch_hit ? tab_q_ff : hit_ff;

      if (cmd.do_req && admit) begin
         if (item_ff.is_write) begin
            wr_cnt_in[ib][iu] = wr_cnt_ff[ib][iu] + 1'b1;
         end else begin
            rd_cnt_in[ib][iu] = rd_cnt_ff[ib][iu] + 1'b1;
            oc_in[ib]         = oc_ff[ib] + 1'b1;
         end
      end

      if (cmd.tick_init) begin
         mask_in = item_ff.downstream_ready[BANK_COUNT-1:0] & nonempty;
      end

      if (cmd.grant) begin
         mask_in    = rest_mask;
         g_bank_in  = gb;
         g_up_in    = gu;
         g_write_in = !found_r;
         g_last_in  = (rest_mask == '0);
         if (found_r) begin
            rd_cnt_in[gb][gu]  = rd_cnt_ff[gb][gu] - 1'b1;
            rd_head_in[gb][gu] = pop_head_nx;
            rd_ptr_in[gb]      = ptr_nx;
         end else begin
            wr_cnt_in[gb][gu]  = wr_cnt_ff[gb][gu] - 1'b1;
            wr_head_in[gb][gu] = pop_head_nx;
            wr_ptr_in[gb]      = ptr_nx;
         end
      end

      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end

      if (cmd.emit_hit) begin
         oc_in[ib] = oc_ff[ib] - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         rd_cnt_ff    <= '{default: '0};
         wr_cnt_ff    <= '{default: '0};
         rd_head_ff   <= '{default: '0};
         wr_head_ff   <= '{default: '0};
         rd_ptr_ff    <= '{default: '0};
         wr_ptr_ff    <= '{default: '0};
         oc_ff        <= '{default: '0};
         mask_ff      <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         rd_cnt_ff    <= rd_cnt_in;
         wr_cnt_ff    <= wr_cnt_in;
         rd_head_ff   <= rd_head_in;
         wr_head_ff   <= wr_head_in;
         rd_ptr_ff    <= rd_ptr_in;
         wr_ptr_ff    <= wr_ptr_in;
         oc_ff        <= oc_in;
         mask_ff      <= mask_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      g_bank_ff  <= g_bank_in;
      g_up_ff    <= g_up_in;
      g_write_ff <= g_write_in;
      g_last_ff  <= g_last_in;
      hit_ff     <= hit_in;
      rsp_ff     <= rsp_in;
   end

   // fifo storage
   always_ff @(posedge clock) begin
      if (cmd.do_req && admit && !item_ff.is_write) begin
         rd_mem[{ib, iu, push_pos}] <= {item_ff.req_addr, item_ff.req_tag};
      end
      if (cmd.grant && found_r) begin
         rd_q_ff <= rd_mem[{gb, gu, pop_head}];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_req && admit && item_ff.is_write) begin
         wr_mem[{ib, iu, push_pos}] <= {item_ff.req_addr, item_ff.req_tag};
      end
      if (cmd.grant && !found_r) begin
         wr_q_ff <= wr_mem[{gb, gu, pop_head}];
      end
   end

   // outstanding table, oldest entry at index zero of each bank
   assign tab_we    = (cmd.do_req && admit && !item_ff.is_write) || cmd.tab_wr_shift;
   assign tab_waddr = cmd.tab_wr_shift ? {ib, idx_ff[PW-1:0]} : {ib, oc_ff[ib][PW-1:0]};
   assign tab_wdata = cmd.tab_wr_shift ? tab_q_ff : {iu, item_ff.req_addr, item_ff.req_tag};
   assign tab_raddr = cmd.tab_rd_next ? {ib, idx_p1[PW-1:0]} : {ib, idx_ff[PW-1:0]};

   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_waddr] <= tab_wdata;
      end
      if (cmd.tab_rd_idx || cmd.tab_rd_next) begin
         tab_q_ff <= tab_mem[tab_raddr];
      end
   end

   // result register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.do_req) begin
         rsp_in.result_kind  = KIND_REQUEST;
         rsp_in.accepted     = admit;
         rsp_in.out_bank     = item_ff.bank;
         rsp_in.out_upstream = item_ff.upstream;
         rsp_in.out_is_write = item_ff.is_write;
         rsp_in.out_addr     = item_ff.req_addr;
         rsp_in.out_tag      = item_ff.req_tag;
         rsp_in.last         = 1'b1;
         rsp_valid_in        = 1'b1;
      end else if (cmd.emit_null) begin
         rsp_in             = '0;
         rsp_in.result_kind = KIND_TICK;
         rsp_in.last        = 1'b1;
         rsp_valid_in       = 1'b1;
      end else if (cmd.emit_grant) begin
         rsp_in.result_kind  = KIND_TICK;
         rsp_in.accepted     = 1'b1;
         rsp_in.out_bank     = 3'(g_bank_ff);
         rsp_in.out_upstream = 2'(g_up_ff);
         rsp_in.out_is_write = g_write_ff;
         rsp_in.out_addr     = g_write_ff ? wr_q_ff[47:16] : rd_q_ff[47:16];
         rsp_in.out_tag      = g_write_ff ? wr_q_ff[15:0] : rd_q_ff[15:0];
         rsp_in.last         = g_last_ff;
         rsp_valid_in        = 1'b1;
      end else if (cmd.emit_hit) begin
         rsp_in.result_kind  = KIND_RESPONSE;
         rsp_in.accepted     = 1'b1;
         rsp_in.out_bank     = item_ff.bank;
         rsp_in.out_upstream = 2'(hit_ff[TW-1:48]);
         rsp_in.out_is_write = 1'b0;
         rsp_in.out_addr     = hit_ff[47:16];
         rsp_in.out_tag      = hit_ff[15:0];
         rsp_in.last         = 1'b1;
         rsp_valid_in        = 1'b1;
      end else if (cmd.emit_miss) begin
         rsp_in.result_kind  = KIND_RESPONSE;
         rsp_in.accepted     = 1'b0;
         rsp_in.out_bank     = item_ff.bank;
         rsp_in.out_upstream = 2'd0;
         rsp_in.out_is_write = 1'b0;
         rsp_in.out_addr     = item_ff.req_addr;
         rsp_in.out_tag      = 16'd0;
         rsp_in.last         = 1'b1;
         rsp_valid_in        = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_comb begin
      status              = '0;
      status.in_kind      = req_item.kind;
      status.out_free     = out_free;
      status.mask_zero    = (mask_ff == '0);
      status.grant_last   = g_last_ff;
      status.bank_ok      = bank_ok;
      status.cnt_zero     = (oc_ff[ib] == '0);
      status.addr_match   = (tab_q_ff[47:16] == item_ff.req_addr);
      status.next_lt_cnt  = idx_p1 < (CW+1)'(oc_ff[ib]);
      status.next2_lt_cnt = idx_p2 < (CW+1)'(oc_ff[ib]);
   end

endmodule

FILE: rtl/banked_memory_request_arbiter.sv
// banked_memory_request_arbiter: top level of the banked request arbiter
// joins the controller bmra_ctrl and the datapath bmra_dp; uses bmra_pkg
//
//   channel  ports                          direction  moves
//   req      req_valid req_stall req_item   in         request, tick or read response item
//   rsp      rsp_valid rsp_stall rsp_item   out        admission, grant or routing item
//   csr      csr_valid csr_ready csr_data   in         buffer limit write
//
// a tick reads one fifo memory entry per granted bank; a read response searches
// the table entries in turn, then shifts each younger entry down (one table
// memory port)
// reset is synchronous and clears all pointers, counts and the limit to 16
// a stalled result holds the controller in its emit state; items are taken only when idle
module banked_memory_request_arbiter
   import bmra_pkg::*;
#(
   parameter int BANK_COUNT     = 8,
   parameter int UPSTREAM_COUNT = 4,
   parameter int BUF_DEPTH      = 16
) (
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_item,
   // result channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_item,
   // limit register write
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [4:0] csr_data
);

   cmd_type    cmd;
   status_type status;

   // limit writes are always taken; send them only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // sequencer
   bmra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // fifos, tables and result register
   bmra_dp #(
      .BANK_COUNT     (BANK_COUNT),
      .UPSTREAM_COUNT (UPSTREAM_COUNT),
      .BUF_DEPTH      (BUF_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data)
   );

endmodule
